/* design/pfat_pkg.sv */
// Shared types and codes for the paged frame allocator and translator.
package pfat_pkg;

    localparam int OPCODE_W = 2;
    localparam int PID_W    = 6;
    localparam int COUNT_W  = 7;
    localparam int LADDR_W  = 21;
    localparam int STATUS_W = 3;
    localparam int PADDR_W  = 25;
    localparam int USED_W   = 11;
    localparam int LIVE_W   = 7;

    localparam logic [OPCODE_W-1:0] OP_CREATE    = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_END       = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_TRANSLATE = 2'd2;
    // Spare code: answered with status ok and no change
    localparam logic [OPCODE_W-1:0] OP_NOP       = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BUSY     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOSPACE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOPID    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UNMAPPED = 3'd4;

    // One result beat.
    typedef struct packed {
        logic [LIVE_W-1:0]   live_processes;
        logic [USED_W-1:0]   used_frames;
        logic [PADDR_W-1:0]  physical_addr;
        logic [STATUS_W-1:0] status;
    } t_result;

endpackage

/* design/pfat_frame_map.sv */
// Used-frame bitmap: registered read port, one write port, clearing pass after reset.
module pfat_frame_map #(
    parameter int NUM_FRAMES = 1024,
    parameter int FW         = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [FW-1:0] i_rd_addr,
    output logic          o_rd_data,
    input  logic          i_wr_en,
    input  logic [FW-1:0] i_wr_addr,
    input  logic          i_wr_data,
    output logic          o_ready
);
    logic          r_mem [NUM_FRAMES];
    logic [FW:0]   r_clr;
    logic          r_rd;

    assign o_ready   = (r_clr == (FW+1)'(NUM_FRAMES));
    assign o_rd_data = r_rd;

    // Clearing sweep, one entry a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (r_clr < (FW+1)'(NUM_FRAMES)) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr < (FW+1)'(NUM_FRAMES)) begin
            r_mem[r_clr[FW-1:0]] <= 1'b0;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd <= r_mem[i_rd_addr];
    end
endmodule

/* design/pfat_page_table.sv */
// Page table memory: one write port, one registered read port.
module pfat_page_table #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int FW    = 10
) (
    input  logic          i_clk,
    input  logic [AW-1:0] i_rd_addr,
    output logic [FW-1:0] o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [FW-1:0] i_wr_data
);
    logic [FW-1:0] r_mem [DEPTH];
    logic [FW-1:0] r_rd;

    assign o_rd_data = r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd <= r_mem[i_rd_addr];
    end
endmodule

/* design/paged_frame_allocator_translator_core.sv */
// Paged frame allocator and translator: one request beat in, one result beat out.
// Requests are handled one at a time; a new request beat is taken only after the
// previous result beat has left. Each request passes a decode state and then an
// output state; translate reads the page table in between, end reads the page
// table and clears the bitmap entry for each page held, and create probes the
// bitmap entries one at a time through the single read port of the bitmap memory,
// with an extra step per frame claimed. After reset the bitmap and the page-count
// table are swept clear before the first request is accepted.
module paged_frame_allocator_translator_core #(
    parameter int NUM_FRAMES = 1024,
    parameter int NUM_PIDS   = 64,
    parameter int MAX_PAGES  = 64,
    parameter int PAGE_BYTES = 32768
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode[1:0], pid[7:2], block_count[14:8], logical_addr[35:15], zero fill
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[2:0], physical_addr[27:3], used_frames[38:28], live_processes[45:39]
    output logic [47:0] m_axis_tdata
);
    localparam int FW   = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int PW   = (NUM_PIDS > 1) ? $clog2(NUM_PIDS) : 1;
    localparam int GW   = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int HW   = $clog2(MAX_PAGES + 1);
    localparam int OW   = $clog2(PAGE_BYTES);
    localparam int AW   = PW + GW;
    localparam int CW   = FW + 1;
    localparam int LW   = PW + 1;

    typedef enum logic [2:0] {
        S_IDLE, S_DEC, S_SCAN, S_FREE_RD, S_FREE_WR, S_XL_RD, S_XL_OUT, S_OUT
    } t_state;

    t_state                       r_state;
    logic [pfat_pkg::OPCODE_W-1:0] r_op;
    logic [pfat_pkg::PID_W-1:0]   r_pid;
    logic [pfat_pkg::COUNT_W-1:0] r_cnt;
    logic [pfat_pkg::LADDR_W-1:0] r_laddr;
    logic [HW-1:0]                r_held [NUM_PIDS];
    logic [HW-1:0]                r_held_q;
    logic [PW:0]                  r_hclr;
    logic [CW-1:0]                r_used;
    logic [LW-1:0]                r_live;
    logic [CW-1:0]                r_k;
    logic [HW-1:0]                r_n;
    logic                         r_pend;
    logic [FW-1:0]                r_pend_k;
    logic                         r_ovalid;
    pfat_pkg::t_result            r_res;

    // Memory ports
    logic          fm_rd_q, fm_we, fm_wd, fm_ready;
    logic [FW-1:0] fm_ra, fm_wa;
    logic          pt_we;
    logic [AW-1:0] pt_ra, pt_wa;
    logic [FW-1:0] pt_rd, pt_wd;
    logic          held_we, held_ready;
    logic [HW-1:0] held_wd;
    logic [PW-1:0] held_ra;

    pfat_frame_map #(.NUM_FRAMES(NUM_FRAMES), .FW(FW)) u_map (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_rd_addr(fm_ra), .o_rd_data(fm_rd_q),
        .i_wr_en(fm_we), .i_wr_addr(fm_wa), .i_wr_data(fm_wd), .o_ready(fm_ready)
    );

    pfat_page_table #(.DEPTH(NUM_PIDS * MAX_PAGES), .AW(AW), .FW(FW)) u_pt (
        .i_clk(i_clk), .i_rd_addr(pt_ra), .o_rd_data(pt_rd),
        .i_wr_en(pt_we), .i_wr_addr(pt_wa), .i_wr_data(pt_wd)
    );

    // Decode helpers
    logic          pid_ok;
    logic [PW-1:0] pid_i;
    logic [HW-1:0] held;
    logic [pfat_pkg::LADDR_W-1:0] page_full;
    logic [OW-1:0] offs;
    logic          scan_last;
    logic          free_last;
    logic [pfat_pkg::STATUS_W-1:0] dec_status;
    t_state        dec_next;

    assign pid_ok    = ({26'd0, r_pid} < 32'(NUM_PIDS));
    assign pid_i     = PW'(r_pid);
    assign held      = r_held_q;
    assign page_full = r_laddr >> OW;
    assign offs      = r_laddr[OW-1:0];
    assign scan_last = (r_state == S_SCAN) && r_pend && (32'(r_n) + 32'd1 == 32'(r_cnt));
    assign free_last = (r_state == S_FREE_WR) && ((r_n + HW'(1)) == held);

    assign held_ready    = (r_hclr == (PW+1)'(NUM_PIDS));
    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid && fm_ready && held_ready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {2'b00, r_res};

    // Page-count table: the read address follows the incoming beat while idle
    assign held_ra = (r_state == S_IDLE) ? PW'(s_axis_tdata[7:2]) : pid_i;
    assign held_we = scan_last || free_last;
    assign held_wd = scan_last ? HW'(r_cnt) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hclr <= '0;
        end else if (r_hclr < (PW+1)'(NUM_PIDS)) begin
            r_hclr <= r_hclr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_hclr < (PW+1)'(NUM_PIDS)) begin
            r_held[r_hclr[PW-1:0]] <= '0;
        end else if (held_we) begin
            r_held[pid_i] <= held_wd;
        end
        r_held_q <= r_held[held_ra];
    end

    // Request decode: status and next state
    always_comb begin
        dec_status = pfat_pkg::ST_OK;
        dec_next   = S_OUT;
        if (r_op != pfat_pkg::OP_NOP && !pid_ok) begin
            dec_status = pfat_pkg::ST_NOPID;
        end else if (r_op == pfat_pkg::OP_CREATE) begin
            if (held != '0 || {25'd0, r_cnt} > 32'(MAX_PAGES)) begin
                dec_status = pfat_pkg::ST_BUSY;
            end else if (r_cnt == '0) begin
                dec_status = pfat_pkg::ST_OK;
            end else if (32'(NUM_FRAMES) - 32'(r_used) < 32'(r_cnt)) begin
                dec_status = pfat_pkg::ST_NOSPACE;
            end else begin
                dec_next = S_SCAN;
            end
        end else if (r_op == pfat_pkg::OP_END) begin
            if (held == '0) begin
                dec_status = pfat_pkg::ST_NOPID;
            end else begin
                dec_next = S_FREE_RD;
            end
        end else if (r_op == pfat_pkg::OP_TRANSLATE) begin
            if (held == '0) begin
                dec_status = pfat_pkg::ST_NOPID;
            end else if (32'(page_full) >= 32'(held)) begin
                dec_status = pfat_pkg::ST_UNMAPPED;
            end else begin
                dec_next = S_XL_RD;
            end
        end
    end

    // Memory address and write control
    always_comb begin
        fm_ra = r_k[FW-1:0];
        fm_we = 1'b0;
        fm_wa = r_pend_k;
        fm_wd = 1'b1;
        pt_we = 1'b0;
        pt_wa = {pid_i, r_n[GW-1:0]};
        pt_wd = r_pend_k;
        pt_ra = {pid_i, GW'(page_full)};
        case (r_state)
            S_SCAN: begin
                fm_ra = r_k[FW-1:0];
            end
            S_FREE_RD: begin
                pt_ra = {pid_i, r_n[GW-1:0]};
            end
            S_FREE_WR: begin
                fm_we = 1'b1;
                fm_wa = pt_rd;
                fm_wd = 1'b0;
            end
            default: begin
            end
        endcase
        if (r_state == S_SCAN && r_pend) begin
            fm_we = 1'b1;
            fm_wa = r_pend_k;
            fm_wd = 1'b1;
            pt_we = 1'b1;
        end
    end

    // Sequencer: bitmap read data is registered and answers the previous address;
    // a probe in flight at a claim is repeated, as its result comes back unused.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_used   <= '0;
            r_live   <= '0;
            r_pend   <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_op    <= s_axis_tdata[1:0];
                        r_pid   <= s_axis_tdata[7:2];
                        r_cnt   <= s_axis_tdata[14:8];
                        r_laddr <= s_axis_tdata[35:15];
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_res.status        <= dec_status;
                    r_res.physical_addr <= '0;
                    r_k    <= '0;
                    r_n    <= '0;
                    r_pend <= 1'b0;
                    r_state <= dec_next;
                end
                S_SCAN: begin
                    // r_k probes; the data seen now belongs to the previous probe
                    if (r_pend) begin
                        r_n    <= r_n + 1'b1;
                        r_pend <= 1'b0;
                        if (scan_last) begin
                            r_used <= r_used + CW'(r_cnt);
                            r_live <= r_live + 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end else if (r_k != '0 && !fm_rd_q) begin
                        // previous probe r_k-1 is free: claim it, re-probe r_k
                        r_pend   <= 1'b1;
                        r_pend_k <= FW'(r_k - 1'b1);
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_FREE_RD: begin
                    r_state <= S_FREE_WR;
                end
                S_FREE_WR: begin
                    r_n <= r_n + 1'b1;
                    if (free_last) begin
                        r_used <= r_used - CW'(held);
                        r_live <= r_live - 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_FREE_RD;
                    end
                end
                S_XL_RD: begin
                    r_state <= S_XL_OUT;
                end
                S_XL_OUT: begin
                    r_res.physical_addr <= pfat_pkg::PADDR_W'({pt_rd, offs});
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_res.used_frames    <= pfat_pkg::USED_W'(r_used);
                    r_res.live_processes <= pfat_pkg::LIVE_W'(r_live);
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Checks
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid) else $error("input taken while result pending");
    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(NUM_FRAMES)) else $error("used frame count overflow");
    a_live_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_live) <= 32'(NUM_PIDS)) else $error("live process count overflow");
endmodule

/* test/paged_frame_allocator_translator_core_checker.sv */
// Checker for the paged frame allocator: predicts every result beat and compares it.
`timescale 1ns / 100ps

module paged_frame_allocator_translator_core_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    // opcode[1:0], pid[7:2], block_count[14:8], logical_addr[35:15], zero fill
    input  logic [39:0] i_req_data,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    // status[2:0], physical_addr[27:3], used_frames[38:28], live_processes[45:39]
    input  logic [47:0] i_res_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_results_seen,
    output int          o_creates_ok,
    output int          o_translates_ok
);

    localparam int FRAMES = 1024;
    localparam int PIDS   = 64;
    localparam int PAGES  = 64;
    localparam int PBYTES = 32768;

    // Shadow allocator state
    bit                frame_busy [FRAMES];
    logic [9:0]        frame_of_page [PIDS*PAGES];
    int                held_pages [PIDS];
    int                frames_in_use;
    int                procs_live;
    pfat_pkg::t_result expected_results [$];

    function automatic pfat_pkg::t_result predict_request(logic [39:0] req);
        logic [pfat_pkg::OPCODE_W-1:0] op;
        int                  pid;
        int                  cnt;
        int                  laddr;
        int                  page;
        int                  k;
        int                  n;
        pfat_pkg::t_result   r;
        op    = req[1:0];
        pid   = req[7:2];
        cnt   = req[14:8];
        laddr = req[35:15];
        r     = '0;
        r.status = pfat_pkg::ST_OK;
        if (op == pfat_pkg::OP_CREATE) begin
            if (held_pages[pid] != 0 || cnt > PAGES) begin
                r.status = pfat_pkg::ST_BUSY;
            end else if (cnt == 0) begin
                r.status = pfat_pkg::ST_OK;
            end else if (FRAMES - frames_in_use < cnt) begin
                r.status = pfat_pkg::ST_NOSPACE;
            end else begin
                k = 0;
                for (n = 0; n < cnt; n++) begin
                    while (frame_busy[k]) k++;
                    frame_busy[k] = 1'b1;
                    frame_of_page[pid*PAGES+n] = k[9:0];
                    k++;
                end
                held_pages[pid] = cnt;
                frames_in_use += cnt;
                procs_live++;
                o_creates_ok++;
            end
        end else if (op == pfat_pkg::OP_END) begin
            if (held_pages[pid] == 0) begin
                r.status = pfat_pkg::ST_NOPID;
            end else begin
                for (n = 0; n < held_pages[pid]; n++)
                    frame_busy[frame_of_page[pid*PAGES+n]] = 1'b0;
                frames_in_use -= held_pages[pid];
                held_pages[pid] = 0;
                procs_live--;
            end
        end else if (op == pfat_pkg::OP_TRANSLATE) begin
            page = laddr / PBYTES;
            if (held_pages[pid] == 0) begin
                r.status = pfat_pkg::ST_NOPID;
            end else if (page >= held_pages[pid]) begin
                r.status = pfat_pkg::ST_UNMAPPED;
            end else begin
                r.physical_addr = pfat_pkg::PADDR_W'(frame_of_page[pid*PAGES+page] * PBYTES
                                                     + laddr % PBYTES);
                o_translates_ok++;
            end
        end
        r.used_frames    = pfat_pkg::USED_W'(frames_in_use);
        r.live_processes = pfat_pkg::LIVE_W'(procs_live);
        return r;
    endfunction

    // Predict on request beats, compare on result beats
    always @(posedge i_clk) begin
        pfat_pkg::t_result got;
        pfat_pkg::t_result want;
        if (!i_rst_n) begin
            foreach (frame_busy[i]) frame_busy[i] = 1'b0;
            foreach (held_pages[i]) held_pages[i] = 0;
            frames_in_use = 0;
            procs_live    = 0;
            expected_results.delete();
            o_fail_count    <= 0;
            o_results_seen  <= 0;
            o_creates_ok     = 0;
            o_translates_ok  = 0;
        end else begin
            if (i_req_valid && i_req_ready)
                expected_results.push_back(predict_request(i_req_data));
            if (i_res_valid && i_res_ready) begin
                got = i_res_data[45:0];
                o_results_seen <= o_results_seen + 1;
                if (expected_results.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("[%0t] result beat with nothing expected: %h", $realtime, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        if (o_fail_count < 10)
                            $display({"[%0t] mismatch: status %0d/%0d phys %h/%h ",
                                      "used %0d/%0d live %0d/%0d (exp/got)"}, $realtime,
                                     want.status, got.status, want.physical_addr,
                                     got.physical_addr, want.used_frames, got.used_frames,
                                     want.live_processes, got.live_processes);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

    assign o_pending = expected_results.size();

endmodule

/* test/paged_frame_allocator_translator_core_tb.sv */
// Testbench top for the paged frame allocator: stimulus, stalls and verdict.
`timescale 1ns / 100ps

module paged_frame_allocator_translator_core_tb;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;     // opcode, pid, block_count, logical_addr
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;     // status, physical_addr, used_frames, live_processes

    int fail_count;
    int pending;
    int results_seen;
    int creates_ok;
    int translates_ok;
    int idle_cycles = 0;
    bit hold_off;

    paged_frame_allocator_translator_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    paged_frame_allocator_translator_core_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (s_axis_tvalid),
        .i_req_ready     (s_axis_tready),
        .i_req_data      (s_axis_tdata),
        .i_res_valid     (m_axis_tvalid),
        .i_res_ready     (m_axis_tready),
        .i_res_data      (m_axis_tdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_results_seen  (results_seen),
        .o_creates_ok    (creates_ok),
        .o_translates_ok (translates_ok)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Watchdog: cycles with no beat accepted on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired, %0d results outstanding", pending);
            $display("paged_frame_allocator_translator_core_tb failed");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        int g;
        bit hold_done;
        hold_done = 1'b0;
        m_axis_tready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (3000) @(posedge i_clk);
                hold_done = 1'b1;
            end
            g = gap_len();
            if (g == 0 || $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
        end
    end

    task automatic send_request(logic [1:0] op, logic [5:0] pid, logic [6:0] cnt,
                                logic [20:0] laddr);
        int g;
        g = gap_len();
        if (g != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, laddr, cnt, pid, op};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    function automatic logic [20:0] addr_in_page(int page);
        return 21'(page * 32768 + $urandom_range(0, 32767));
    endfunction

    initial begin
        int          k;
        int          sel;
        logic [5:0]  pid;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every opcode, field extremes and rejection cases
        send_request(pfat_pkg::OP_TRANSLATE, 6'd0, 7'd0, 21'd0);      // no pid live
        send_request(pfat_pkg::OP_END, 6'd63, 7'd0, 21'd0);           // end on dead pid
        send_request(pfat_pkg::OP_CREATE, 6'd1, 7'd0, 21'd0);         // zero count
        send_request(pfat_pkg::OP_CREATE, 6'd1, 7'd65, 21'd0);        // count too large
        send_request(pfat_pkg::OP_CREATE, 6'd2, 7'd127, 21'h1FFFFF);  // far too large
        send_request(pfat_pkg::OP_CREATE, 6'd0, 7'd64, 21'd0);        // largest count
        send_request(pfat_pkg::OP_CREATE, 6'd0, 7'd3, 21'd0);         // pid busy
        send_request(pfat_pkg::OP_TRANSLATE, 6'd0, 7'd0, 21'h1FFFFF); // last page, last byte
        send_request(pfat_pkg::OP_TRANSLATE, 6'd0, 7'h7F, 21'd0);
        send_request(pfat_pkg::OP_CREATE, 6'd63, 7'd5, 21'd0);
        send_request(pfat_pkg::OP_TRANSLATE, 6'd63, 7'd0, 21'(5 * 32768)); // unmapped page
        send_request(pfat_pkg::OP_TRANSLATE, 6'd63, 7'd0, 21'(4 * 32768 + 32767));
        send_request(pfat_pkg::OP_NOP, 6'h3F, 7'h7F, 21'h1FFFFF);     // spare opcode
        send_request(pfat_pkg::OP_NOP, 6'd0, 7'd0, 21'd0);
        send_request(pfat_pkg::OP_END, 6'd0, 7'd0, 21'd0);            // free hole at low frames
        send_request(pfat_pkg::OP_CREATE, 6'd5, 7'd10, 21'd0);        // refills the hole
        // fill the frames until space runs out
        for (k = 10; k < 26; k++) send_request(pfat_pkg::OP_CREATE, 6'(k), 7'd64, 21'd0);
        send_request(pfat_pkg::OP_END, 6'd63, 7'd0, 21'd0);

        // Random: lifecycles with random content, some noise
        for (k = 0; k < 560; k++) begin
            if (k == 200) hold_off = 1'b1;
            sel = $urandom_range(0, 99);
            pid = 6'($urandom_range(0, 63));
            if (sel < 25)
                send_request(pfat_pkg::OP_CREATE, pid,
                             7'($urandom_range(0, 3) == 0 ? $urandom_range(0, 127)
                                                          : $urandom_range(1, 40)),
                             21'($urandom));
            else if (sel < 40)
                send_request(pfat_pkg::OP_END, pid, 7'($urandom), 21'($urandom));
            else if (sel < 85)
                send_request(pfat_pkg::OP_TRANSLATE, pid, 7'($urandom),
                             $urandom_range(0, 3) == 0 ? 21'($urandom)
                                                       : addr_in_page($urandom_range(0, 8)));
            else if (sel < 95)
                send_request(pfat_pkg::OP_CREATE, pid, 7'd64, 21'($urandom));
            else
                send_request(pfat_pkg::OP_NOP, pid, 7'($urandom), 21'($urandom));
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (2000) @(posedge i_clk);

        $display("covered %0d results: %0d mapped creates, %0d translations to a frame",
                 results_seen, creates_ok, translates_ok);
        if (fail_count == 0 && pending == 0)
            $display("paged_frame_allocator_translator_core_tb passed");
        else
            $display("paged_frame_allocator_translator_core_tb failed");
        $finish;
    end

endmodule
